@@ rtl/tlc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types and constants of the two-level cache tag model.
// ----------------------------------------------------------------------------
package tlc_pkg;

  // sizes
  localparam int LINE_W       = 32;
  localparam int SETV_W       = 15;
  localparam int LAT_W        = 12;
  localparam int CYC_W        = 10;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 10;
  localparam int IN_DATA_W    = 32;
  localparam int OUT_DATA_W   = 16;

  // default geometry
  localparam int DEF_L1_MAX_SETS = 256;
  localparam int DEF_L1_WAYS     = 4;
  localparam int DEF_L2_MAX_SETS = 1024;
  localparam int DEF_L2_WAYS     = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_L1_SET_BITS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_L2_SET_BITS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ALLOC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_L1_CYCLES   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_L2_CYCLES   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_CYCLES  = 3'd6;

  // access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // row update kinds
  typedef enum logic [1:0] {
    WR_CLEAR,
    WR_TOUCH,
    WR_FILL,
    WR_DROP
  } wr_op_t;

  // lookup status of one level
  typedef struct packed {
    logic              hit;
    logic              evict;
    logic [LINE_W-1:0] victim;
  } look_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV1,
    S_DIV2,
    S_LOOK,
    S_V1,
    S_V2,
    S_V3,
    S_RD1,
    S_FILL,
    S_OUT
  } state_t;

endpackage

@@ rtl/tlc_set_idx.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlc_set_idx
// Masked line address modulo the set count, by reciprocal multiply, two stages.
// ----------------------------------------------------------------------------
module tlc_set_idx #(
  parameter int MAX_SETS = 256,
  parameter int IDX_W    = 8
) (
  input  logic                      clk,
  input  logic                      start,
  input  logic [tlc_pkg::SETV_W-1:0] val,
  output logic [IDX_W-1:0]          idx
);
  import tlc_pkg::*;

  localparam int    SHIFT  = 30;
  localparam int    RCP_W  = SHIFT + 1;
  localparam int    PROD_W = SETV_W + RCP_W;
  localparam longint RECIP = ((64'd1 << SHIFT) / MAX_SETS) + 1;

  logic [SETV_W-1:0] v1;
  logic [PROD_W-1:0] prod;
  logic [SETV_W:0]   quo;
  logic [SETV_W+16:0] qm;
  logic [SETV_W-1:0] rem;

  // stage one: value times reciprocal
  always_ff @(posedge clk) begin
    if (start) begin
      v1   <= val;
      prod <= PROD_W'(val) * PROD_W'(RCP_W'(RECIP));
    end
  end

  // stage two: exact quotient, subtract back
  always_comb begin
    quo = prod[PROD_W-1 -: SETV_W+1];
    qm  = (SETV_W+17)'(quo) * (SETV_W+17)'(17'(MAX_SETS));
    rem = v1 - qm[SETV_W-1:0];
  end

  always_ff @(posedge clk) begin
    idx <= rem[IDX_W-1:0];
  end

endmodule

@@ rtl/tlc_level.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlc_level
// Tag and LRU row memory of one cache level with lookup, touch, fill and drop.
// ----------------------------------------------------------------------------
module tlc_level #(
  parameter int SETS  = 256,
  parameter int WAYS  = 4,
  parameter int IDX_W = 8
) (
  input  logic                       clk,
  input  logic [IDX_W-1:0]           rd_addr,
  input  logic [tlc_pkg::LINE_W-1:0] ln,
  input  logic                       wr_en,
  input  tlc_pkg::wr_op_t            wr_op,
  input  logic [IDX_W-1:0]           wr_addr,
  output tlc_pkg::look_t             look
);
  import tlc_pkg::*;

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  // row storage: valid, rank, line per way
  logic [WAYS-1:0]                vmem [SETS];
  logic [WAYS-1:0][WAY_W-1:0]     rmem [SETS];
  logic [WAYS-1:0][LINE_W-1:0]    lmem [SETS];

  logic [WAYS-1:0]                rv, nv;
  logic [WAYS-1:0][WAY_W-1:0]     rr, nr;
  logic [WAYS-1:0][LINE_W-1:0]    rl, nl;

  logic [WAYS-1:0] hv;
  logic [WAY_W-1:0] hit_way, pick, tw;
  logic found, inv_found;
  logic [WAY_W:0] old;

  // registered read
  always_ff @(posedge clk) begin
    rv <= vmem[rd_addr];
    rr <= rmem[rd_addr];
    rl <= lmem[rd_addr];
  end

  // row write back
  always_ff @(posedge clk) begin
    if (wr_en) begin
      vmem[wr_addr] <= nv;
      rmem[wr_addr] <= nr;
      lmem[wr_addr] <= nl;
    end
  end

  // lookup, victim choice and row update
  always_comb begin
    hv        = '0;
    hit_way   = '0;
    found     = 1'b0;
    pick      = '0;
    inv_found = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      hv[w] = rv[w] && (rl[w] == ln);
    end
    for (int w = 0; w < WAYS; w++) begin
      if (hv[w] && !found) begin
        hit_way = WAY_W'(w);
        found   = 1'b1;
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (!rv[w] && !inv_found) begin
        pick      = WAY_W'(w);
        inv_found = 1'b1;
      end
    end
    // no free way: oldest way goes
    if (!inv_found) begin
      for (int w = 1; w < WAYS; w++) begin
        if (rr[w] > rr[pick]) pick = WAY_W'(w);
      end
    end
    tw  = (wr_op == WR_FILL) ? pick : hit_way;
    old = rv[tw] ? {1'b0, rr[tw]} : (WAY_W+1)'(WAYS);
    nv  = rv;
    nr  = rr;
    nl  = rl;
    unique case (wr_op)
      WR_CLEAR: begin
        nv = '0;
        nr = '0;
        nl = '0;
      end
      WR_TOUCH, WR_FILL: begin
        for (int i = 0; i < WAYS; i++) begin
          if (WAY_W'(i) != tw && rv[i] && {1'b0, rr[i]} < old) nr[i] = rr[i] + 1'b1;
        end
        nr[tw] = '0;
        if (wr_op == WR_FILL) begin
          nv[tw] = 1'b1;
          nl[tw] = ln;
        end
      end
      WR_DROP: begin
        nv[tw] = 1'b0;
        for (int i = 0; i < WAYS; i++) begin
          if (WAY_W'(i) != tw && rv[i] && rr[i] > rr[tw]) nr[i] = rr[i] - 1'b1;
        end
      end
      default: begin
        nv = rv;
      end
    endcase
    look.hit    = found;
    look.evict  = !inv_found;
    look.victim = rl[pick];
  end

endmodule

@@ rtl/two_level_lru_cache_tag_model_core.sv @@
`timescale 1ns / 1ps
// Sequence: accept in S_IDLE, set index and row read in S_DIV1 and S_DIV2, lookup in S_LOOK,
//   result in S_OUT; an evicting L2 fill adds back-invalidate states S_V1 to S_FILL
// Accesses: a new one is taken only in S_IDLE, after the previous result is loaded,
//   so a result stall holds the input as well
// Reset: clearing pass over the max of the L1 and L2 set counts with s_tready low
// ----------------------------------------------------------------------------
// two_level_lru_cache_tag_model_core
// Two-level inclusive set-associative tag model with true LRU per set.
// ----------------------------------------------------------------------------
module two_level_lru_cache_tag_model_core #(
  parameter int L1_MAX_SETS = tlc_pkg::DEF_L1_MAX_SETS,
  parameter int L1_WAYS     = tlc_pkg::DEF_L1_WAYS,
  parameter int L2_MAX_SETS = tlc_pkg::DEF_L2_MAX_SETS,
  parameter int L2_WAYS     = tlc_pkg::DEF_L2_WAYS
) (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [tlc_pkg::IN_DATA_W-1:0]  s_tdata,   // address
  input  logic                           s_tuser,   // op
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [tlc_pkg::OUT_DATA_W-1:0] m_tdata,   // latency[11:0], l1_hit, l2_hit, pad
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tlc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tlc_pkg::*;

  localparam int L1_IDX_W = (L1_MAX_SETS > 1) ? $clog2(L1_MAX_SETS) : 1;
  localparam int L2_IDX_W = (L2_MAX_SETS > 1) ? $clog2(L2_MAX_SETS) : 1;
  localparam int CLR_N    = (L1_MAX_SETS > L2_MAX_SETS) ? L1_MAX_SETS : L2_MAX_SETS;
  localparam int CNT_W    = $clog2(CLR_N + 1);

  state_t state, state_next;

  // configuration registers
  logic [4:0]       block_bits;
  logic [3:0]       l1_set_bits, l2_set_bits;
  logic             alloc_writes;
  logic [CYC_W-1:0] l1_cycles, l2_cycles, mem_cycles;

  logic [CNT_W-1:0]    clr_cnt;
  logic [LINE_W-1:0]   ln, ln_in, victim;
  logic                alloc;
  logic [L1_IDX_W-1:0] s1, l1_idx, l1_rd, l1_wa;
  logic [L2_IDX_W-1:0] l2_idx, l2_wa;
  logic [SETV_W-1:0]   l1_mask, l2_mask, l1_val;
  logic                l1_start, l2_start;
  logic                l1_we, l2_we;
  wr_op_t              l1_op, l2_op;
  logic [LINE_W-1:0]   l1_cmp;
  look_t               l1_look, l2_look;
  logic [LAT_W-1:0]    lat;
  logic                h1, h2, res_load;
  logic                in_acc;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign ln_in     = s_tdata >> block_bits;
  assign l1_mask   = SETV_W'((16'd1 << l1_set_bits) - 16'd1);
  assign l2_mask   = SETV_W'((16'd1 << l2_set_bits) - 16'd1);

  // configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      block_bits   <= 5'd5;
      l1_set_bits  <= 4'd4;
      l2_set_bits  <= 4'd6;
      alloc_writes <= 1'b1;
      l1_cycles    <= 10'd1;
      l2_cycles    <= 10'd5;
      mem_cycles   <= 10'd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BLOCK_BITS:  block_bits   <= cfg_data[4:0];
        REG_L1_SET_BITS: l1_set_bits  <= cfg_data[3:0];
        REG_L2_SET_BITS: l2_set_bits  <= cfg_data[3:0];
        REG_WRITE_ALLOC: alloc_writes <= cfg_data[0];
        REG_L1_CYCLES:   l1_cycles    <= cfg_data;
        REG_L2_CYCLES:   l2_cycles    <= cfg_data;
        REG_MEM_CYCLES:  mem_cycles   <= cfg_data;
        default:         block_bits   <= block_bits;
      endcase
    end
  end

  // set index units
  assign l1_start = in_acc || (state == S_LOOK);
  assign l2_start = in_acc;
  assign l1_val   = in_acc ? (ln_in[SETV_W-1:0] & l1_mask)
                           : (l2_look.victim[SETV_W-1:0] & l1_mask);

  tlc_set_idx #(.MAX_SETS(L1_MAX_SETS), .IDX_W(L1_IDX_W)) u_l1_idx (
    .clk(clk), .start(l1_start), .val(l1_val), .idx(l1_idx)
  );

  tlc_set_idx #(.MAX_SETS(L2_MAX_SETS), .IDX_W(L2_IDX_W)) u_l2_idx (
    .clk(clk), .start(l2_start), .val(ln_in[SETV_W-1:0] & l2_mask), .idx(l2_idx)
  );

  // level memories
  tlc_level #(.SETS(L1_MAX_SETS), .WAYS(L1_WAYS), .IDX_W(L1_IDX_W)) u_l1 (
    .clk(clk), .rd_addr(l1_rd), .ln(l1_cmp), .wr_en(l1_we), .wr_op(l1_op),
    .wr_addr(l1_wa), .look(l1_look)
  );

  tlc_level #(.SETS(L2_MAX_SETS), .WAYS(L2_WAYS), .IDX_W(L2_IDX_W)) u_l2 (
    .clk(clk), .rd_addr(l2_idx), .ln(ln), .wr_en(l2_we), .wr_op(l2_op),
    .wr_addr(l2_wa), .look(l2_look)
  );

  // item registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ln    <= ln_in;
      alloc <= (s_tuser == OP_READ) || alloc_writes;
    end
    if (state == S_DIV2) s1 <= l1_idx;
    if (state == S_LOOK) begin
      victim <= l2_look.victim;
      h1     <= l1_look.hit;
      h2     <= !l1_look.hit && l2_look.hit;
      if (l1_look.hit) begin
        lat <= LAT_W'(l1_cycles);
      end else if (l2_look.hit) begin
        lat <= LAT_W'(l1_cycles) + LAT_W'(l2_cycles);
      end else begin
        lat <= LAT_W'(l1_cycles) + LAT_W'(l2_cycles) + LAT_W'(mem_cycles);
      end
    end
  end

  // state and clear counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // sequencer: next state and memory controls
  always_comb begin
    state_next = state;
    l1_rd      = s1;
    l1_cmp     = ln;
    l1_we      = 1'b0;
    l1_op      = WR_CLEAR;
    l1_wa      = s1;
    l2_we      = 1'b0;
    l2_op      = WR_CLEAR;
    l2_wa      = l2_idx;
    res_load   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        l1_wa = clr_cnt[L1_IDX_W-1:0];
        l2_wa = clr_cnt[L2_IDX_W-1:0];
        l1_we = clr_cnt < CNT_W'(L1_MAX_SETS);
        l2_we = clr_cnt < CNT_W'(L2_MAX_SETS);
        if (clr_cnt == CNT_W'(CLR_N - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) state_next = S_DIV1;
      end
      S_DIV1: begin
        state_next = S_DIV2;
      end
      S_DIV2: begin
        l1_rd      = l1_idx;
        state_next = S_LOOK;
      end
      S_LOOK: begin
        state_next = S_OUT;
        if (l1_look.hit) begin
          l1_we = 1'b1;
          l1_op = WR_TOUCH;
        end else if (l2_look.hit) begin
          l2_we = 1'b1;
          l2_op = WR_TOUCH;
          l1_we = alloc;
          l1_op = WR_FILL;
        end else if (alloc) begin
          l2_we = 1'b1;
          l2_op = WR_FILL;
          if (l2_look.evict) begin
            state_next = S_V1;
          end else begin
            l1_we = 1'b1;
            l1_op = WR_FILL;
          end
        end
      end
      S_V1: begin
        state_next = S_V2;
      end
      S_V2: begin
        l1_rd      = l1_idx;
        state_next = S_V3;
      end
      S_V3: begin
        // back-invalidate the line that left L2
        l1_cmp     = victim;
        l1_wa      = l1_idx;
        l1_we      = l1_look.hit;
        l1_op      = WR_DROP;
        state_next = S_RD1;
      end
      S_RD1: begin
        state_next = S_FILL;
      end
      S_FILL: begin
        l1_we      = 1'b1;
        l1_op      = WR_FILL;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) m_tdata <= {2'b00, h2, h1, lat};
  end

endmodule

@@ tb/two_level_lru_cache_tag_model_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_lru_cache_tag_model_core_test
// Drives cache accesses and configuration writes into the two-level tag
// model and compares every latency and hit flag with a local LRU model.
// ----------------------------------------------------------------------------
module two_level_lru_cache_tag_model_core_test;
  import tlc_pkg::*;

  localparam int L1S = 256, L1W = 4, L2S = 1024, L2W = 8;

  typedef struct packed {
    logic [11:0] latency;
    logic        l1_hit;
    logic        l2_hit;
  } access_res_t;

  // ---------------------------------------------------------------------------
  // scoreboard: tag/LRU model and queue of expected access results
  // ---------------------------------------------------------------------------
  class cache_scoreboard;
    bit        v1[L1S*L1W];
    bit [31:0] ln1[L1S*L1W];
    int        rk1[L1S*L1W];
    bit        v2[L2S*L2W];
    bit [31:0] ln2[L2S*L2W];
    int        rk2[L2S*L2W];
    bit [4:0]  blk_bits;
    bit [3:0]  s1_bits, s2_bits;
    bit        wr_alloc;
    bit [9:0]  c1, c2, cm;
    access_res_t pending_res[$];
    int        errors;

    function new();
      blk_bits = 5; s1_bits = 4; s2_bits = 6; wr_alloc = 1;
      c1 = 1; c2 = 5; cm = 100; errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [9:0] val);
      case (idx)
        REG_BLOCK_BITS:  blk_bits = val[4:0];
        REG_L1_SET_BITS: s1_bits = val[3:0];
        REG_L2_SET_BITS: s2_bits = val[3:0];
        REG_WRITE_ALLOC: wr_alloc = val[0];
        REG_L1_CYCLES:   c1 = val;
        REG_L2_CYCLES:   c2 = val;
        REG_MEM_CYCLES:  cm = val;
        default: ;
      endcase
    endfunction

    function int base_of(bit [31:0] ln, bit [3:0] bits, int sets, int ways);
      bit [31:0] m;
      m = (32'd1 << bits) - 1;
      return ((ln & m) % sets) * ways;
    endfunction

    // way index of a valid match, or -1
    function int find1(int b, bit [31:0] ln);
      for (int w = 0; w < L1W; w++) if (v1[b+w] && ln1[b+w] == ln) return w;
      return -1;
    endfunction

    function int find2(int b, bit [31:0] ln);
      for (int w = 0; w < L2W; w++) if (v2[b+w] && ln2[b+w] == ln) return w;
      return -1;
    endfunction

    function void touch1(int b, int w);
      int old;
      old = v1[b+w] ? rk1[b+w] : L1W;
      for (int i = 0; i < L1W; i++) if (i != w && v1[b+i] && rk1[b+i] < old) rk1[b+i]++;
      rk1[b+w] = 0;
    endfunction

    function void touch2(int b, int w);
      int old;
      old = v2[b+w] ? rk2[b+w] : L2W;
      for (int i = 0; i < L2W; i++) if (i != w && v2[b+i] && rk2[b+i] < old) rk2[b+i]++;
      rk2[b+w] = 0;
    endfunction

    function void fill1(int b, bit [31:0] ln);
      int pick;
      pick = -1;
      for (int w = 0; w < L1W; w++) if (pick < 0 && !v1[b+w]) pick = w;
      if (pick < 0) begin
        pick = 0;
        for (int w = 1; w < L1W; w++) if (rk1[b+w] > rk1[b+pick]) pick = w;
      end
      touch1(b, pick);
      v1[b+pick] = 1;
      ln1[b+pick] = ln;
    endfunction

    // fill L2; back-invalidate the evicted line in L1
    function void fill2(int b, bit [31:0] ln);
      int pick, vb, vw, old;
      bit [31:0] vic;
      bit ev;
      pick = -1;
      ev = 0;
      for (int w = 0; w < L2W; w++) if (pick < 0 && !v2[b+w]) pick = w;
      if (pick < 0) begin
        pick = 0;
        for (int w = 1; w < L2W; w++) if (rk2[b+w] > rk2[b+pick]) pick = w;
        vic = ln2[b+pick];
        ev = 1;
      end
      touch2(b, pick);
      v2[b+pick] = 1;
      ln2[b+pick] = ln;
      if (ev) begin
        vb = base_of(vic, s1_bits, L1S, L1W);
        vw = find1(vb, vic);
        if (vw >= 0) begin
          old = rk1[vb+vw];
          v1[vb+vw] = 0;
          for (int i = 0; i < L1W; i++)
            if (i != vw && v1[vb+i] && rk1[vb+i] > old) rk1[vb+i]--;
        end
      end
    endfunction

    // note an accepted access and queue its expected result
    function void note_access(bit op, bit [31:0] addr);
      bit [31:0] ln;
      int b1, b2, w;
      bit alloc;
      access_res_t r;
      ln = addr >> blk_bits;
      b1 = base_of(ln, s1_bits, L1S, L1W);
      b2 = base_of(ln, s2_bits, L2S, L2W);
      alloc = (op == OP_READ) || wr_alloc;
      r = '0;
      w = find1(b1, ln);
      if (w >= 0) begin
        r.l1_hit = 1;
        touch1(b1, w);
        r.latency = 12'(c1);
      end else begin
        w = find2(b2, ln);
        if (w >= 0) begin
          r.l2_hit = 1;
          touch2(b2, w);
          if (alloc) fill1(b1, ln);
          r.latency = 12'(c1) + 12'(c2);
        end else begin
          if (alloc) begin
            fill2(b2, ln);
            fill1(b1, ln);
          end
          r.latency = 12'(c1) + 12'(c2) + 12'(cm);
        end
      end
      pending_res = {pending_res, r};
    endfunction

    function void report(string what);
      $display("mismatch: %s", what);
      errors++;
    endfunction

    function void check_result(logic [15:0] data);
      access_res_t e;
      if (pending_res.size() == 0) begin
        report($sformatf("unexpected result %h", data));
        return;
      end
      e = pending_res.pop_front();
      if (data[11:0] !== e.latency)
        report($sformatf("latency %0d, want %0d", data[11:0], e.latency));
      if (data[12] !== e.l1_hit)
        report($sformatf("l1_hit %b, want %b", data[12], e.l1_hit));
      if (data[13] !== e.l2_hit)
        report($sformatf("l2_hit %b, want %b", data[13], e.l2_hit));
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tuser = 0, m_tready = 0, cfg_valid = 0;
  logic [31:0] s_tdata = '0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tready, m_tvalid, cfg_ready;
  logic [15:0] m_tdata;

  cache_scoreboard sb = new();
  int  cycle_count = 0;
  bit  calm = 0;
  bit  [31:0] recent_addr[$];

  always #5 clk = ~clk;

  two_level_lru_cache_tag_model_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // result side: check each beat, stall in random bursts
  always @(posedge clk) begin
    int stall;
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (stall > 0) begin
        stall--;
        m_tready <= 0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 17) - 1;
        m_tready <= 0;
      end else m_tready <= 1;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("** two_level_lru_cache_tag_model_core: FAILED **");
      $finish;
    end
  end

  // valid stays up after the beat so that the next access can follow directly
  task automatic send_access(bit op, bit [31:0] addr);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= addr;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_access(op, addr);
    recent_addr = {recent_addr, addr};
    if (recent_addr.size() > 24) void'(recent_addr.pop_front());
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending_res.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [9:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // address with locality so that hits, fills and evictions all occur
  function automatic bit [31:0] pick_addr();
    int k;
    k = $urandom_range(0, 9);
    if (k < 4 && recent_addr.size() > 0)
      return recent_addr[$urandom_range(0, recent_addr.size() - 1)] ^ $urandom_range(0, 3);
    if (k < 8)
      return {12'h0, 4'($urandom_range(0, 15)), 16'h0}
             | ($urandom_range(0, 63) << sb.blk_bits) | $urandom_range(0, 3);
    return $urandom();
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send_access(1'($urandom_range(0, 1)), pick_addr());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    // directed: extremes and all three outcomes at reset settings
    send_access(OP_READ, 32'h0);
    send_access(OP_READ, 32'h0);
    send_access(OP_WRITE, 32'hFFFF_FFFF);
    send_access(OP_WRITE, 32'hFFFF_FFFF);
    // fill one L2 set past its ways to force eviction and back-invalidate
    for (int i = 0; i < 10; i++) send_access(OP_READ, i << 11);
    for (int i = 0; i < 4; i++) send_access(OP_READ, i << 11);
    send_access(OP_WRITE, 32'hAAAA_5555);
    send_access(OP_READ, 32'h5555_AAAA);
    drain();
    // write without allocate, extreme latencies
    write_reg(REG_WRITE_ALLOC, 0);
    write_reg(REG_L1_CYCLES, 1023);
    write_reg(REG_L2_CYCLES, 1023);
    write_reg(REG_MEM_CYCLES, 1023);
    send_access(OP_WRITE, 32'h1234_0000);
    send_access(OP_WRITE, 32'h1234_0000);
    send_access(OP_READ, 32'h0);
    drain();
    // tiny caches: zero set bits, zero block bits, zero latencies
    write_reg(REG_BLOCK_BITS, 0);
    write_reg(REG_L1_SET_BITS, 0);
    write_reg(REG_L2_SET_BITS, 0);
    write_reg(REG_L1_CYCLES, 0);
    write_reg(REG_L2_CYCLES, 0);
    write_reg(REG_MEM_CYCLES, 0);
    random_phase(100);
    drain();
    // wide sets with wrap, large blocks, allocate on
    write_reg(REG_BLOCK_BITS, 31);
    write_reg(REG_L1_SET_BITS, 15);
    write_reg(REG_L2_SET_BITS, 15);
    write_reg(REG_WRITE_ALLOC, 1);
    write_reg(REG_L1_CYCLES, 10'($urandom_range(0, 1023)));
    write_reg(REG_L2_CYCLES, 10'($urandom_range(0, 1023)));
    write_reg(REG_MEM_CYCLES, 10'($urandom_range(0, 1023)));
    random_phase(60);
    drain();
    write_reg(REG_BLOCK_BITS, 16);
    write_reg(REG_L1_SET_BITS, 8);
    write_reg(REG_L2_SET_BITS, 10);
    random_phase(100);
    drain();
    write_reg(REG_BLOCK_BITS, 4);
    write_reg(REG_L1_SET_BITS, 2);
    write_reg(REG_L2_SET_BITS, 3);
    write_reg(REG_WRITE_ALLOC, 0);
    random_phase(90);
    drain();
    // last part without idling
    calm = 1;
    write_reg(REG_WRITE_ALLOC, 1);
    random_phase(100);
    drain();
    if (sb.errors == 0 && sb.pending_res.size() == 0)
      $display("** two_level_lru_cache_tag_model_core: PASSED **");
    else
      $display("** two_level_lru_cache_tag_model_core: FAILED **");
    $finish;
  end
endmodule

@@ files.f @@
rtl/tlc_pkg.sv
rtl/tlc_set_idx.sv
rtl/tlc_level.sv
rtl/two_level_lru_cache_tag_model_core.sv
tb/two_level_lru_cache_tag_model_core_test.sv
